@@ rtl/bia_pkg.sv @@
// Shared types, constants and helpers for the bitmap identifier allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bia_pkg;

  localparam int NUM_IDS   = 1024;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int ID_W      = 10;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   widx_t;
  typedef logic [BIT_AW-1:0]    bidx_t;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            grant_ok;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_MOD
  } state_e;

  // Write-back notice from the datapath to the full-flag summary.
  typedef struct packed {
    logic  we;
    widx_t idx;
    logic  full;
  } sum_upd_t;

  // Lowest word that still has a free identifier.
  typedef struct packed {
    logic  any_free;
    widx_t idx;
  } sum_pick_t;

  // Bits of word w that stand for identifiers below NUM_IDS.
  function automatic word_t valid_mask(widx_t w);
    int    remain;
    word_t mask;
    remain = NUM_IDS - int'(w) * WORD_BITS;
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (i < remain);
    end
    return mask;
  endfunction

endpackage

@@ rtl/bia_word_ram.sv @@
// Usage bitmap storage: one word per WORD_BITS identifiers.
// Single write port, single read port, registered read data. Uses bia_pkg.
`timescale 1ns / 1ps

module bia_word_ram
  import bia_pkg::*;
(
  input  logic  clk_i,
  input  logic  rd_en_i,
  input  widx_t rd_addr_i,
  input  logic  we_i,
  input  widx_t wr_addr_i,
  input  word_t wr_data_i,
  output word_t rd_data_o
);

  word_t mem [NWORDS];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/bia_summary.sv @@
// Per-word full flags and written flags, plus the lowest not-full word pick.
// Reset marks every word free and unwritten. Uses bia_pkg.
`timescale 1ns / 1ps

module bia_summary
  import bia_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sum_upd_t  upd_i,
  input  widx_t     chk_idx_i,
  output logic      chk_written_o,
  output sum_pick_t pick_o
);

  logic [NWORDS-1:0] full_q, full_d;
  logic [NWORDS-1:0] written_q, written_d;

  always_comb begin
    full_d    = full_q;
    written_d = written_q;
    if (upd_i.we) begin
      full_d[upd_i.idx]    = upd_i.full;
      written_d[upd_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q    <= '0;
      written_q <= '0;
    end else begin
      full_q    <= full_d;
      written_q <= written_d;
    end
  end

  // Priority pick: scan from the top so the lowest not-full word wins.
  always_comb begin
    pick_o.idx      = '0;
    pick_o.any_free = ~&full_q;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        pick_o.idx = WORD_AW'(i);
      end
    end
  end

  assign chk_written_o = written_q[chk_idx_i];

endmodule

@@ rtl/bitmap_id_allocator.sv @@
// Bitmap identifier allocator: hands out the lowest free identifier of
// NUM_IDS and takes identifiers back. Uses bia_pkg, bia_word_ram, bia_summary.
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request (in_req_i):
//   action 0 allocates, action 1 frees release_id. A free request gives
//   no response; a free of an identifier at or above NUM_IDS is dropped.
//   Output channel out_valid_o / out_stall_i carries one response per
//   allocate request (out_rsp_o), with granted_id 0 and grant_ok 0 when
//   the pool is exhausted.
// Sequence and throughput:
//   The accept edge issues the memory read of the target word (picked at
//   once from the full-flag summary); the write-back edge in ST_MOD writes
//   the word back and loads the response register. A new request is taken
//   only in ST_IDLE, after the previous one has been written back.
// Stall:
//   Hold the response while out_stall_i is high. An allocate that finishes
//   behind a stalled response waits in its write-back cycle, stalling input.
// Reset:
//   Asynchronous, active low. Clear the full and written flags; an
//   unwritten word reads as all free, so no clearing pass is needed.
`timescale 1ns / 1ps

module bitmap_id_allocator
  import bia_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  state_e    state_q, state_d;
  req_t      req_q;
  widx_t     word_q;
  logic      any_free_q;
  logic      out_valid_q, out_valid_d;
  rsp_t      rsp_q, rsp_d;

  logic      accept;
  widx_t     rd_addr;
  widx_t     rel_word;
  bidx_t     rel_bit;
  logic      rel_in_range;
  word_t     rd_data;
  logic      chk_written;
  sum_pick_t pick;
  sum_upd_t  upd;

  word_t     cur_word;
  word_t     free_bits;
  bidx_t     alloc_bit;
  word_t     new_word;
  logic      is_alloc;
  logic      out_busy;
  logic      mod_done;
  logic      load_rsp;

  // Input side: take a request only when idle.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  assign rel_word = WORD_AW'(in_req_i.release_id >> BIT_AW);
  assign rd_addr  = (in_req_i.action == ACT_FREE) ? rel_word : pick.idx;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= in_req_i;
      word_q     <= rd_addr;
      any_free_q <= pick.any_free;
    end
  end

  bia_word_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .we_i      (upd.we),
    .wr_addr_i (word_q),
    .wr_data_i (new_word),
    .rd_data_o (rd_data)
  );

  bia_summary u_summary (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (upd),
    .chk_idx_i     (word_q),
    .chk_written_o (chk_written),
    .pick_o        (pick)
  );

  // Modify: a word never written reads as all free.
  assign cur_word     = chk_written ? rd_data : '0;
  assign free_bits    = ~cur_word & valid_mask(word_q);
  assign rel_bit      = BIT_AW'(req_q.release_id);
  assign rel_in_range = (32'(req_q.release_id) < NUM_IDS);
  assign is_alloc     = (req_q.action == ACT_ALLOC);

  // Lowest clear bit of the chosen word.
  always_comb begin
    alloc_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        alloc_bit = BIT_AW'(i);
      end
    end
  end

  always_comb begin
    if (is_alloc) begin
      new_word = cur_word | (word_t'(1) << alloc_bit);
    end else begin
      new_word = cur_word & ~(word_t'(1) << rel_bit);
    end
  end

  assign out_busy = out_valid_q & out_stall_i;
  assign mod_done = ~(is_alloc & out_busy);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the write-back cycle.
  always_comb begin
    upd.we   = 1'b0;
    upd.idx  = word_q;
    upd.full = &(new_word | ~valid_mask(word_q));
    load_rsp = 1'b0;
    case (state_q)
      ST_IDLE: begin
        upd.we   = 1'b0;
        load_rsp = 1'b0;
      end
      ST_MOD: begin
        if (mod_done) begin
          load_rsp = is_alloc;
          upd.we   = is_alloc ? any_free_q : rel_in_range;
        end
      end
      default: begin
        upd.we   = 1'b0;
        load_rsp = 1'b0;
      end
    endcase
  end

  // Response register: load on completion, drop once taken.
  always_comb begin
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    if (load_rsp) begin
      out_valid_d      = 1'b1;
      rsp_d.grant_ok   = any_free_q;
      rsp_d.granted_id = any_free_q ? ID_W'({word_q, alloc_bit}) : '0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ dv/tb_bitmap_id_allocator.sv @@
// Self-checking testbench for bitmap_id_allocator: directed and random requests,
// with a bitmap predictor and a queue of expected grants. Depends on bia_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator;
  import bia_pkg::*;

  localparam int IDLE_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT = 20;    // settle time after the last grant
  localparam int HOLD_OFF   = 300;   // one long receiver stall to back the block up
  localparam int DIR_N      = 18;

  // One directed row: the request, plus a grant typed in by hand where it
  // is obvious. Rows that are not pinned are checked against the predictor.
  typedef struct {
    logic            action;
    logic [ID_W-1:0] rid;
    bit              pinned;
    logic [ID_W-1:0] gid;
    logic            ok;
  } dir_row_t;

  dir_row_t dir_tab [DIR_N] = '{
    '{ACT_ALLOC, 10'd0,    1'b1, 10'd0, 1'b1},  // first grant after reset
    '{ACT_ALLOC, 10'd1023, 1'b1, 10'd1, 1'b1},  // release_id ignored on allocate
    '{ACT_ALLOC, 10'h155,  1'b1, 10'd2, 1'b1},
    '{ACT_FREE,  10'd1,    1'b0, 10'd0, 1'b0},
    '{ACT_ALLOC, 10'd0,    1'b1, 10'd1, 1'b1},  // hole is refilled first
    '{ACT_FREE,  10'd1,    1'b0, 10'd0, 1'b0},
    '{ACT_FREE,  10'd1,    1'b0, 10'd0, 1'b0},  // double free
    '{ACT_ALLOC, 10'h2AA,  1'b1, 10'd1, 1'b1},
    '{ACT_FREE,  10'd1023, 1'b0, 10'd0, 1'b0},  // top identifier, never taken
    '{ACT_ALLOC, 10'd0,    1'b1, 10'd3, 1'b1},
    '{ACT_FREE,  10'd0,    1'b0, 10'd0, 1'b0},
    '{ACT_FREE,  10'd0,    1'b0, 10'd0, 1'b0},  // double free of identifier zero
    '{ACT_ALLOC, 10'd0,    1'b1, 10'd0, 1'b1},
    '{ACT_FREE,  10'd2,    1'b0, 10'd0, 1'b0},
    '{ACT_ALLOC, 10'd0,    1'b1, 10'd2, 1'b1},
    '{ACT_FREE,  10'h3FE,  1'b0, 10'd0, 1'b0},  // already free
    '{ACT_ALLOC, 10'd0,    1'b1, 10'd4, 1'b1},
    '{ACT_ALLOC, 10'h3FF,  1'b0, 10'd0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  req_t in_req = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  // Predictor state: one usage bit per identifier, 1 = in use.
  logic [NUM_IDS-1:0] id_in_use = '0;
  rsp_t grant_q[$];

  int  err_cnt   = 0;
  int  req_idx   = 0;
  int  n_alloc   = 0;
  int  n_free    = 0;
  int  n_grant   = 0;
  int  n_exhaust = 0;
  int  idle_cnt  = 0;
  bit  quiet_in  = 1'b0;
  bit  stim_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bitmap_id_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // Apply one accepted request to the bitmap; return 1 when it yields a response.
  function automatic bit apply_request(input req_t r, output rsp_t g);
    int id;
    g = '0;
    if (r.action == ACT_FREE) begin
      // Drop frees beyond the pool; clearing a free bit is harmless.
      if (int'(r.release_id) < NUM_IDS) id_in_use[r.release_id] = 1'b0;
      return 1'b0;
    end
    for (id = 0; id < NUM_IDS; id++) begin
      if (!id_in_use[id]) break;
    end
    // Pool exhausted leaves the grant at zero and the bitmap untouched.
    if (id < NUM_IDS) begin
      id_in_use[id] = 1'b1;
      g.granted_id = id[ID_W-1:0];
      g.grant_ok   = 1'b1;
    end
    return 1'b1;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random request; frees lean toward the low, densely used identifiers.
  function automatic req_t rand_request(input int alloc_pct);
    req_t r;
    r.action     = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
    r.release_id = ID_W'($urandom_range(0, 1023));
    if (r.action == ACT_FREE && $urandom_range(0, 9) < 7)
      r.release_id = ID_W'($urandom_range(0, $urandom_range(31, 1023)));
    return r;
  endfunction

  // Offer one request starting at a falling edge; return at the falling
  // edge after it was taken. Valid stays high across back-to-back requests.
  task automatic send_request(input req_t r);
    int gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic run_segment(input int n, input int alloc_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      send_request(rand_request(alloc_pct));
    end
  endtask

  // Sender: reset, directed rows, then fill / drain / mixed random phases.
  initial begin
    req_t r;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DIR_N; i++) begin
      r.action     = dir_tab[i].action;
      r.release_id = dir_tab[i].rid;
      send_request(r);
    end
    // Fill past exhaustion with a few frees mixed in, then drain, then mix.
    run_segment(1150, 98);
    run_segment(250, 15);
    repeat (4) run_segment(60, $urandom_range(30, 70));
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall stretches, quiet spells without stall, and one
  // long hold-off so the block backs up and stalls its input.
  initial begin
    bit held;
    bit quiet_out;
    bit stall;
    int n;
    held      = 1'b0;
    quiet_out = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) quiet_out = !quiet_out;
      if (!held && n_grant + n_exhaust >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        n = HOLD_OFF;
      end else if (quiet_out) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 8);
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        out_stall <= stall;
        n = stall ? pick_gap() + 1 : $urandom_range(1, 4);
      end
      repeat (n) @(negedge clk_i);
    end
  end

  // Monitor: check grants against the oldest expectation, predict accepted
  // requests, and count idle cycles for the watchdog.
  always @(posedge clk_i) begin : mon_b
    rsp_t want;
    rsp_t calc;
    bit   has;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (out_rsp.grant_ok) n_grant++;
        else n_exhaust++;
        if (grant_q.size() == 0) begin
          $error("grant with nothing outstanding: granted_id %0d grant_ok %0b",
                 out_rsp.granted_id, out_rsp.grant_ok);
          err_cnt++;
        end else begin
          want = grant_q.pop_front();
          if (out_rsp.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d", want.granted_id, out_rsp.granted_id);
            err_cnt++;
          end
          if (out_rsp.grant_ok !== want.grant_ok) begin
            $error("grant_ok: expected %0b, got %0b", want.grant_ok, out_rsp.grant_ok);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        has = apply_request(in_req, calc);
        if (in_req.action == ACT_ALLOC) n_alloc++;
        else n_free++;
        // Pinned directed rows override the predictor's grant.
        if (req_idx < DIR_N && dir_tab[req_idx].pinned) begin
          calc.granted_id = dir_tab[req_idx].gid;
          calc.grant_ok   = dir_tab[req_idx].ok;
        end
        if (has) grant_q.push_back(calc);
        req_idx++;
      end
      idle_cnt = moved ? 0 : idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb_bitmap_id_allocator: done, errors");
        $finish;
      end
    end
  end

  // End of run: wait out the outstanding grants, then a short settle time
  // to catch stray responses.
  initial begin
    wait (stim_done);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("%0d requests: %0d allocate, %0d free", req_idx, n_alloc, n_free);
    $display("%0d grants, %0d pool-exhausted replies, %0d errors",
             n_grant, n_exhaust, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_bitmap_id_allocator: done, clean");
    end else begin
      $display("tb_bitmap_id_allocator: done, errors");
    end
    $finish;
  end

endmodule
